[rtl/rpa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and tables for the point-about-axis rotation pipeline.
// No dependencies.
package rpa_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  // geometry front end depth, and the delay that lines u/v up with sin/cos
  localparam int GEOM_STAGES = 7;
  localparam int UV_DELAY = STEPS_EFF + 2 - GEOM_STAGES;
  localparam int LATENCY = STEPS_EFF + 4;

  localparam int A_W   = 16;
  localparam int D_W   = 33;
  localparam int P_W   = A_W + D_W;
  localparam int DOT_W = 37;
  localparam int PR_W  = A_W + DOT_W;
  localparam int U_W   = 40;
  localparam int M_W   = A_W + U_W;
  localparam int V_W   = 43;
  localparam int CW    = 34;
  localparam int CS_W  = 23;
  localparam int PC_W  = U_W + CS_W;
  localparam int PS_W  = V_W + CS_W;
  localparam int R_W   = PS_W + 1;

  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  localparam int CORDIC_GAIN_Q30 = 652032874;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] turn_angle;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic               overflowed;
  } res_t;

  typedef struct packed {
    logic signed [2:0][U_W-1:0] u;
    logic signed [2:0][V_W-1:0] v;
  } uv_t;

  typedef struct packed {
    logic signed [CS_W-1:0] cos_m1;
    logic signed [CS_W-1:0] sin;
  } sc_t;

endpackage

[rtl/rpa_geom.sv]
`timescale 1ns / 1ps
// Geometry front end: offset from pivot, projection, perpendicular part and
// axis cross product, seven register stages. Depends on rpa_pkg.
module rpa_geom (
  input  logic          clk_i,
  input  rpa_pkg::req_t req_i,
  output rpa_pkg::uv_t  uv_o
);

  logic signed [rpa_pkg::A_W-1:0]   a1_q [3], a2_q [3], a3_q [3], a4_q [3], a5_q [3];
  logic signed [rpa_pkg::D_W-1:0]   d1_q [3], d2_q [3], d3_q [3], d4_q [3];
  logic signed [rpa_pkg::P_W-1:0]   p2_q [3];
  logic signed [rpa_pkg::DOT_W-1:0] dot3_q;
  logic signed [rpa_pkg::PR_W-1:0]  pr4_q [3];
  logic signed [rpa_pkg::U_W-1:0]   u5_q [3], u6_q [3], u7_q [3];
  logic signed [rpa_pkg::M_W-1:0]   m6_q [6];
  logic signed [rpa_pkg::V_W-1:0]   v7_q [3];

  logic signed [rpa_pkg::P_W+2:0]   sum_w;
  logic signed [rpa_pkg::A_W-1:0]   ain [3];
  logic signed [31:0]               pin [3], qin [3];

  assign ain = '{req_i.axis_x, req_i.axis_y, req_i.axis_z};
  assign pin = '{req_i.pivot_x, req_i.pivot_y, req_i.pivot_z};
  assign qin = '{req_i.point_x, req_i.point_y, req_i.point_z};

  assign sum_w = (rpa_pkg::P_W+3)'(p2_q[0]) + (rpa_pkg::P_W+3)'(p2_q[1])
               + (rpa_pkg::P_W+3)'(p2_q[2]) + ((rpa_pkg::P_W+3)'(1) <<< 13);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      a1_q[k]  <= ain[k];
      d1_q[k]  <= rpa_pkg::D_W'(qin[k]) - rpa_pkg::D_W'(pin[k]);
      a2_q[k]  <= a1_q[k];
      d2_q[k]  <= d1_q[k];
      p2_q[k]  <= rpa_pkg::P_W'(a1_q[k]) * rpa_pkg::P_W'(d1_q[k]);
      a3_q[k]  <= a2_q[k];
      d3_q[k]  <= d2_q[k];
      a4_q[k]  <= a3_q[k];
      d4_q[k]  <= d3_q[k];
      pr4_q[k] <= rpa_pkg::PR_W'(a3_q[k]) * rpa_pkg::PR_W'(dot3_q);
      a5_q[k]  <= a4_q[k];
      u5_q[k]  <= rpa_pkg::U_W'(d4_q[k])
                - rpa_pkg::U_W'((pr4_q[k] + (rpa_pkg::PR_W'(1) <<< 13)) >>> 14);
      u6_q[k]  <= u5_q[k];
      u7_q[k]  <= u6_q[k];
      v7_q[k]  <= rpa_pkg::V_W'(((rpa_pkg::M_W+1)'(m6_q[2*k]) - (rpa_pkg::M_W+1)'(m6_q[2*k+1])
                + ((rpa_pkg::M_W+1)'(1) <<< 13)) >>> 14);
    end
    dot3_q  <= rpa_pkg::DOT_W'(sum_w >>> 14);
    m6_q[0] <= rpa_pkg::M_W'(a5_q[1]) * rpa_pkg::M_W'(u5_q[2]);
    m6_q[1] <= rpa_pkg::M_W'(a5_q[2]) * rpa_pkg::M_W'(u5_q[1]);
    m6_q[2] <= rpa_pkg::M_W'(a5_q[2]) * rpa_pkg::M_W'(u5_q[0]);
    m6_q[3] <= rpa_pkg::M_W'(a5_q[0]) * rpa_pkg::M_W'(u5_q[2]);
    m6_q[4] <= rpa_pkg::M_W'(a5_q[0]) * rpa_pkg::M_W'(u5_q[1]);
    m6_q[5] <= rpa_pkg::M_W'(a5_q[1]) * rpa_pkg::M_W'(u5_q[0]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      uv_o.u[k] = u7_q[k];
      uv_o.v[k] = v7_q[k];
    end
  end

endmodule

[rtl/rpa_cordic.sv]
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC, one iteration per stage, plus quadrant
// fold and rounding to Q.20. Depends on rpa_pkg.
module rpa_cordic (
  input  logic               clk_i,
  input  logic signed [15:0] angle_i,
  output rpa_pkg::sc_t       sc_o
);

  localparam int NS = rpa_pkg::STEPS_EFF;

  logic signed [rpa_pkg::CW-1:0] x_q [NS+1];
  logic signed [rpa_pkg::CW-1:0] y_q [NS+1];
  logic signed [rpa_pkg::CW-1:0] z_q [NS+1];
  logic                          flip_q [NS+1];
  logic signed [15:0]            ang_w;
  logic                          flip_w;
  logic signed [rpa_pkg::CW:0]   rx_w, ry_w;
  logic signed [rpa_pkg::CS_W-1:0] cs_w, sn_w;

  assign flip_w = (angle_i > 16'sd16384) || (angle_i < -16'sd16384);
  assign ang_w  = flip_w ? (angle_i ^ 16'sh8000) : angle_i;

  always_ff @(posedge clk_i) begin
    x_q[0]    <= rpa_pkg::CW'(rpa_pkg::CORDIC_GAIN_Q30);
    y_q[0]    <= '0;
    z_q[0]    <= {{(rpa_pkg::CW-30){ang_w[15]}}, ang_w, 14'b0};
    flip_q[0] <= flip_w;
  end

  for (genvar j = 1; j <= NS; j++) begin : g_iter
    localparam logic signed [rpa_pkg::CW-1:0] AT = rpa_pkg::CW'(rpa_pkg::ATAN_TURNS[j-1]);
    always_ff @(posedge clk_i) begin
      flip_q[j] <= flip_q[j-1];
      if (z_q[j-1] >= 0) begin
        x_q[j] <= x_q[j-1] - (y_q[j-1] >>> (j-1));
        y_q[j] <= y_q[j-1] + (x_q[j-1] >>> (j-1));
        z_q[j] <= z_q[j-1] - AT;
      end else begin
        x_q[j] <= x_q[j-1] + (y_q[j-1] >>> (j-1));
        y_q[j] <= y_q[j-1] - (x_q[j-1] >>> (j-1));
        z_q[j] <= z_q[j-1] + AT;
      end
    end
  end

  assign rx_w = ((rpa_pkg::CW+1)'(x_q[NS]) + (rpa_pkg::CW+1)'(512)) >>> 10;
  assign ry_w = ((rpa_pkg::CW+1)'(y_q[NS]) + (rpa_pkg::CW+1)'(512)) >>> 10;
  assign cs_w = flip_q[NS] ? -rpa_pkg::CS_W'(rx_w) : rpa_pkg::CS_W'(rx_w);
  assign sn_w = flip_q[NS] ? -rpa_pkg::CS_W'(ry_w) : rpa_pkg::CS_W'(ry_w);

  always_ff @(posedge clk_i) begin
    sc_o.cos_m1 <= cs_w - rpa_pkg::CS_W'(1 << 20);
    sc_o.sin    <= sn_w;
  end

endmodule

[rtl/rpa_delay.sv]
`timescale 1ns / 1ps
// Shift line that holds the perpendicular vectors until sine and cosine are
// ready. Depends on rpa_pkg.
module rpa_delay (
  input  logic         clk_i,
  input  rpa_pkg::uv_t uv_i,
  output rpa_pkg::uv_t uv_o
);

  rpa_pkg::uv_t tap_q [rpa_pkg::UV_DELAY];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= uv_i;
    for (int k = 1; k < rpa_pkg::UV_DELAY; k++) begin
      tap_q[k] <= tap_q[k-1];
    end
  end

  assign uv_o = tap_q[rpa_pkg::UV_DELAY-1];

endmodule

[rtl/rpa_blend.sv]
`timescale 1ns / 1ps
// Final two stages: U*(cos-1) + V*sin, rounding to Q16.16 and saturation.
// Depends on rpa_pkg.
module rpa_blend (
  input  logic         clk_i,
  input  rpa_pkg::uv_t uv_i,
  input  rpa_pkg::sc_t sc_i,
  output rpa_pkg::res_t res_o
);

  localparam logic signed [rpa_pkg::R_W-1:0] MAXV = rpa_pkg::R_W'(2147483647);
  localparam logic signed [rpa_pkg::R_W-1:0] MINV = ~MAXV;

  logic signed [rpa_pkg::PC_W-1:0] pc_q [3];
  logic signed [rpa_pkg::PS_W-1:0] ps_q [3];
  logic signed [rpa_pkg::R_W-1:0]  r_w [3];
  logic signed [31:0]              o_w [3];
  logic [2:0]                      sat_w;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pc_q[k] <= rpa_pkg::PC_W'($signed(uv_i.u[k])) * rpa_pkg::PC_W'(sc_i.cos_m1);
      ps_q[k] <= rpa_pkg::PS_W'($signed(uv_i.v[k])) * rpa_pkg::PS_W'(sc_i.sin);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_w[k] = (rpa_pkg::R_W'(pc_q[k]) + rpa_pkg::R_W'(ps_q[k])
              + (rpa_pkg::R_W'(1) <<< 19)) >>> 20;
      sat_w[k] = 1'b1;
      if (r_w[k] > MAXV) begin
        o_w[k] = 32'sh7fffffff;
      end else if (r_w[k] < MINV) begin
        o_w[k] = 32'sh80000000;
      end else begin
        o_w[k]   = r_w[k][31:0];
        sat_w[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.offset_x   <= o_w[0];
    res_o.offset_y   <= o_w[1];
    res_o.offset_z   <= o_w[2];
    res_o.overflowed <= |sat_w;
  end

endmodule

[rtl/rotate_point_about_axis_core.sv]
`timescale 1ns / 1ps
// Top level of the point-about-axis rotation pipeline.
// Depends on rpa_pkg, rpa_geom, rpa_cordic, rpa_delay, rpa_blend.
//
// Usage:
//   Request channel: drive req_i and raise start_i; a request is taken at
//   every rising edge with start_i high and busy_o low. busy_o stays low,
//   so one request can enter every cycle.
//   Result channel: done_o is high for exactly one cycle with res_o, the
//   offset from the point to its rotated position, saturated, plus an
//   overflow flag. The receiver cannot hold results off.
//   Result path: the CORDIC pipeline, one iteration per stage, plus a fold
//   stage, a rounding stage and two multiply/round stages; the geometry
//   path is delayed to match it.
//   Throughput: one request per cycle.
//   Reset: rst_ni clears the valid chain only; requests in flight are
//   dropped and no result strobes after reset until a new request arrives.
module rotate_point_about_axis_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  rpa_pkg::req_t req_i,
  output logic          done_o,
  output rpa_pkg::res_t res_o
);

  logic [rpa_pkg::LATENCY-1:0] vld_q, vld_d;
  rpa_pkg::uv_t                uv_w, uvd_w;
  rpa_pkg::sc_t                sc_w;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[rpa_pkg::LATENCY-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  rpa_geom u_geom (
    .clk_i (clk_i),
    .req_i (req_i),
    .uv_o  (uv_w)
  );

  rpa_cordic u_cordic (
    .clk_i   (clk_i),
    .angle_i (req_i.turn_angle),
    .sc_o    (sc_w)
  );

  rpa_delay u_delay (
    .clk_i (clk_i),
    .uv_i  (uv_w),
    .uv_o  (uvd_w)
  );

  rpa_blend u_blend (
    .clk_i (clk_i),
    .uv_i  (uvd_w),
    .sc_i  (sc_w),
    .res_o (res_o)
  );

  assign done_o = vld_q[rpa_pkg::LATENCY-1];

endmodule

[rtl/rpa_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the rotation pipeline, bound to the top level.
// Depends on rpa_pkg and rotate_point_about_axis_core.
module rpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input rpa_pkg::res_t res_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(rpa_pkg::LATENCY) done_o)
    else $error("missing result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##(rpa_pkg::LATENCY) !done_o)
    else $error("result without request");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.overflowed) |->
      (res_o.offset_x == 32'sh7fffffff || res_o.offset_x == 32'sh80000000 ||
       res_o.offset_y == 32'sh7fffffff || res_o.offset_y == 32'sh80000000 ||
       res_o.offset_z == 32'sh7fffffff || res_o.offset_z == 32'sh80000000))
    else $error("overflow flag without saturated component");

endmodule

bind rotate_point_about_axis_core rpa_checker u_rpa_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);

[tb/rotate_point_about_axis_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for rotate_point_about_axis_core: directed and random requests,
// offsets predicted by a bit-accurate fixed-point model with its own CORDIC.
// Depends on rpa_pkg and the core RTL.
module rotate_point_about_axis_core_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM = 530;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  rpa_pkg::req_t req_i = '0;
  logic done_o;
  rpa_pkg::res_t res_o;

  rpa_pkg::res_t expected_offsets[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int idle_cycles = 0;
  int overflow_seen = 0;

  const logic [31:0] ANGLE_STEP [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  rotate_point_about_axis_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .done_o(done_o), .res_o(res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint rnd_shr(longint v, int n);
    longint t;
    t = v + (longint'(1) << (n - 1));
    return t >>> n;
  endfunction

  function automatic void sin_cos(input logic signed [15:0] ang, output longint sn,
                                  output longint cs);
    logic signed [15:0] a;
    logic flip;
    longint x, y, z, dx, dy;
    int steps;
    a = ang;
    flip = 1'b0;
    if (ang > 16384 || ang < -16384) begin
      a = ang + 16'sh8000;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = longint'(a) * 16384;
    steps = (rpa_pkg::CORDIC_STEPS > 24) ? 24 : rpa_pkg::CORDIC_STEPS;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ANGLE_STEP[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ANGLE_STEP[i]);
      end
    end
    x = rnd_shr(x, 10);
    y = rnd_shr(y, 10);
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic rpa_pkg::res_t rotation_offset(rpa_pkg::req_t r);
    longint a[3], d[3], u[3], v[3];
    longint dot, sn, cs, c1, t;
    rpa_pkg::res_t o;
    a[0] = r.axis_x; a[1] = r.axis_y; a[2] = r.axis_z;
    d[0] = longint'(r.point_x) - longint'(r.pivot_x);
    d[1] = longint'(r.point_y) - longint'(r.pivot_y);
    d[2] = longint'(r.point_z) - longint'(r.pivot_z);
    dot = rnd_shr(a[0] * d[0] + a[1] * d[1] + a[2] * d[2], 14);
    for (int i = 0; i < 3; i++) u[i] = d[i] - rnd_shr(a[i] * dot, 14);
    v[0] = rnd_shr(a[1] * u[2] - a[2] * u[1], 14);
    v[1] = rnd_shr(a[2] * u[0] - a[0] * u[2], 14);
    v[2] = rnd_shr(a[0] * u[1] - a[1] * u[0], 14);
    sin_cos(r.turn_angle, sn, cs);
    c1 = cs - 1048576;
    o.overflowed = 1'b0;
    for (int i = 0; i < 3; i++) begin
      t = rnd_shr(u[i] * c1 + v[i] * sn, 20);
      if (t > 64'sd2147483647) begin
        t = 64'sd2147483647; o.overflowed = 1'b1;
      end
      if (t < -64'sd2147483648) begin
        t = -64'sd2147483648; o.overflowed = 1'b1;
      end
      if (i == 0) o.offset_x = t[31:0];
      else if (i == 1) o.offset_y = t[31:0];
      else o.offset_z = t[31:0];
    end
    return o;
  endfunction

  // hold start until the request is taken
  task automatic send_request(rpa_pkg::req_t r);
    req_i <= r;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    expected_offsets.push_back(rotation_offset(r));
    sent++;
  endtask

  task automatic pause(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rpa_pkg::res_t e;
    if (rst_ni) begin
      idle_cycles <= (done_o || (start_i && !busy_o)) ? 0 : idle_cycles + 1;
      if (done_o) begin
        received++;
        if (expected_offsets.size() == 0) begin
          $error("unexpected result %h", res_o);
          errors++;
        end else begin
          e = expected_offsets.pop_front();
          if (res_o.overflowed) overflow_seen++;
          if (res_o.offset_x !== e.offset_x) begin
            $error("offset_x expected %0d got %0d", e.offset_x, res_o.offset_x); errors++;
          end
          if (res_o.offset_y !== e.offset_y) begin
            $error("offset_y expected %0d got %0d", e.offset_y, res_o.offset_y); errors++;
          end
          if (res_o.offset_z !== e.offset_z) begin
            $error("offset_z expected %0d got %0d", e.offset_z, res_o.offset_z); errors++;
          end
          if (res_o.overflowed !== e.overflowed) begin
            $error("overflowed expected %0b got %0b", e.overflowed, res_o.overflowed);
            errors++;
          end
        end
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] unit_like();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic rpa_pkg::req_t random_request();
    rpa_pkg::req_t r;
    int k;
    k = $urandom_range(3);
    r.turn_angle = 16'($urandom);
    if (k == 0) begin
      r.axis_x = 16'sd0; r.axis_y = 16'sd0; r.axis_z = 16'sd0;
      case ($urandom_range(2))
        0: r.axis_x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        1: r.axis_y = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        default: r.axis_z = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      endcase
    end else if (k == 1) begin
      r.axis_x = 16'sd9459; r.axis_y = $urandom_range(1) ? 16'sd9459 : -16'sd9459;
      r.axis_z = $urandom_range(1) ? 16'sd9459 : -16'sd9459;
    end else begin
      r.axis_x = unit_like(); r.axis_y = unit_like(); r.axis_z = unit_like();
    end
    if ($urandom_range(3) == 0) begin
      r.pivot_x = $urandom; r.pivot_y = $urandom; r.pivot_z = $urandom;
      r.point_x = $urandom; r.point_y = $urandom; r.point_z = $urandom;
    end else begin
      r.pivot_x = $signed($urandom) >>> $urandom_range(20, 1);
      r.pivot_y = $signed($urandom) >>> $urandom_range(20, 1);
      r.pivot_z = $signed($urandom) >>> $urandom_range(20, 1);
      r.point_x = $signed($urandom) >>> $urandom_range(20, 1);
      r.point_y = $signed($urandom) >>> $urandom_range(20, 1);
      r.point_z = $signed($urandom) >>> $urandom_range(20, 1);
    end
    return r;
  endfunction

  task automatic test_angles();
    rpa_pkg::req_t r;
    logic signed [15:0] angs[9] = '{16'sh8000, 16'sh7FFF, 16'sd16384, 16'sd16385,
      -16'sd16384, -16'sd16385, 16'sd0, 16'sd1, -16'sd1};
    foreach (angs[i]) begin
      r = '0;
      r.axis_z = 16'sd16384;
      r.point_x = 32'sd65536 * 5; r.point_y = -32'sd65536 * 3; r.point_z = 32'sd7;
      r.pivot_x = 32'sd65536;
      r.turn_angle = angs[i];
      send_request(r);
    end
  endtask

  task automatic test_extremes();
    rpa_pkg::req_t r;
    r = '0;
    r.axis_x = -16'sd16384; r.turn_angle = 16'sh4000;
    r.point_y = 32'sh7FFFFFFF; r.pivot_y = 32'sh80000000;
    r.point_z = 32'sh80000000; r.pivot_z = 32'sh7FFFFFFF;
    send_request(r);
    r.turn_angle = 16'sh8000;
    send_request(r);
    r = '1;
    send_request(r);
    r = '0;
    r.axis_x = 16'sh7FFF; r.axis_y = 16'sh8000; r.axis_z = 16'sh7FFF;
    r.turn_angle = 16'sh2000;
    r.point_x = 32'sh7FFFFFFF; r.point_y = 32'sh80000000; r.point_z = 32'sh7FFFFFFF;
    r.pivot_x = 32'sh80000000; r.pivot_y = 32'sh7FFFFFFF; r.pivot_z = 32'sh80000000;
    send_request(r);
    r = '0;
    r.axis_x = 16'sd100; r.axis_y = 16'sd5; r.turn_angle = 16'sh1234;
    r.point_x = 32'sd123456; r.point_y = -32'sd98765; r.point_z = 32'sd55555;
    send_request(r);
    pause(1);
  endtask

  task automatic test_random();
    int burst;
    int left;
    left = N_RANDOM;
    while (left > 0) begin
      burst = ($urandom_range(3) == 0) ? 40 : $urandom_range(12, 1);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_request(random_request());
        left--;
      end
      if ($urandom_range(2) != 0) pause($urandom_range(25, 1));
    end
    start_i <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_angles();
    test_extremes();
    test_random();
    while (expected_offsets.size() != 0) @(posedge clk_i);
    repeat (rpa_pkg::LATENCY + 5) @(posedge clk_i);
    $display("Covered %0d requests, %0d results, %0d with saturation.",
             sent, received, overflow_seen);
    if (errors == 0 && expected_offsets.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/rpa_pkg.sv
rtl/rpa_geom.sv
rtl/rpa_cordic.sv
rtl/rpa_delay.sv
rtl/rpa_blend.sv
rtl/rotate_point_about_axis_core.sv
rtl/rpa_checker.sv
tb/rotate_point_about_axis_core_tb.sv
